// ===== design/hcr_pkg.sv =====
`timescale 1ns / 1ps
package hcr_pkg;

    localparam int COEF_W  = 32;
    localparam int CFG_IW  = 3;
    localparam int QUO_W   = 17;
    localparam int OUT_W   = 16;

    localparam logic [CFG_IW-1:0] REG_XX = 3'd0;
    localparam logic [CFG_IW-1:0] REG_XY = 3'd1;
    localparam logic [CFG_IW-1:0] REG_XC = 3'd2;
    localparam logic [CFG_IW-1:0] REG_WX = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WY = 3'd4;

    localparam logic signed [OUT_W-1:0] OUT_MAX    = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN    = 16'sh8000;
    localparam logic signed [OUT_W-1:0] OUT_ABSENT = -16'sd1;

    // per-beat control that travels with the divider data
    typedef struct packed {
        logic valid;
        logic absent;
        logic special;
        logic sat_neg;
        logic neg;
    } beat_ctl_t;

endpackage

// ===== design/hcr_div_cell.sv =====
`timescale 1ns / 1ps
module hcr_div_cell #(
    parameter int MAG_W = 66,
    parameter int SHIFT = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  hcr_pkg::beat_ctl_t        ctl_in,
    input  logic [MAG_W-1:0]          rem_in,
    input  logic [MAG_W-1:0]          div_in,
    input  logic [hcr_pkg::QUO_W-1:0] quo_in,
    output hcr_pkg::beat_ctl_t        ctl_out,
    output logic [MAG_W-1:0]          rem_out,
    output logic [MAG_W-1:0]          div_out,
    output logic [hcr_pkg::QUO_W-1:0] quo_out
);
    import hcr_pkg::*;

    logic [MAG_W:0]   trial;
    logic             take;
    beat_ctl_t        ctl_reg;
    logic [MAG_W-1:0] rem_reg;
    logic [MAG_W-1:0] div_reg;
    logic [QUO_W-1:0] quo_reg;

    // one restoring step: subtract the shifted divisor if it fits
    assign trial = {1'b0, rem_in} - ({1'b0, div_in} << SHIFT);
    assign take  = ~trial[MAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= take ? trial[MAG_W-1:0] : rem_in;
            div_reg <= div_in;
            quo_reg <= {quo_in[QUO_W-2:0], take};
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign div_out = div_reg;
    assign quo_out = quo_reg;

endmodule

// ===== design/homography_column_remap.sv =====
`timescale 1ns / 1ps
// throughput: one beat per cycle while no output beat is held;
// a 17-cell restoring divider chain sets the depth
// the whole pipeline holds while an output beat waits, and in_ready is low only then
// reset: asynchronous active low; clears all valid flags, coef_xx to 1.0 and
// the other coefficients to zero
module homography_column_remap #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [hcr_pkg::CFG_IW-1:0]            cfg_index,
    input  logic [hcr_pkg::COEF_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [COORD_BITS-1:0]                 row_index,
    input  logic signed [COORD_BITS:0]            col_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [hcr_pkg::OUT_W-1:0]      col_out
);
    import hcr_pkg::*;

    // product width and sum width of numerator / denominator
    localparam int PROD_W = COEF_W + COORD_BITS + 2;
    localparam int SUM_W  = PROD_W + 2;
    // divider magnitude width: room for the divisor shifted by QUO_W
    localparam int MAG_W  = SUM_W + QUO_W + 2;

    // coefficient registers
    logic signed [COEF_W-1:0] coef_xx_reg;
    logic signed [COEF_W-1:0] coef_xy_reg;
    logic signed [COEF_W-1:0] coef_xc_reg;
    logic signed [COEF_W-1:0] coef_wx_reg;
    logic signed [COEF_W-1:0] coef_wy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= COEF_W'(64'sd1 <<< FRAC_BITS);
            coef_xy_reg <= '0;
            coef_xc_reg <= '0;
            coef_wx_reg <= '0;
            coef_wy_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XX:  coef_xx_reg <= cfg_data;
                REG_XY:  coef_xy_reg <= cfg_data;
                REG_XC:  coef_xc_reg <= cfg_data;
                REG_WX:  coef_wx_reg <= cfg_data;
                REG_WY:  coef_wy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the output beat is held
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // stage 1: the four products
    logic signed [COORD_BITS+1:0] x_s;
    logic signed [COORD_BITS+1:0] y_s;
    assign x_s = {col_in[COORD_BITS], col_in};
    assign y_s = {2'b00, row_index};

    logic                     s1_valid_reg;
    logic                     s1_absent_reg;
    logic signed [PROD_W-1:0] p_xx_reg;
    logic signed [PROD_W-1:0] p_xy_reg;
    logic signed [PROD_W-1:0] p_wx_reg;
    logic signed [PROD_W-1:0] p_wy_reg;
    logic signed [COEF_W-1:0] s1_xc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // operands sign-extended to the full product width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_absent_reg <= col_in[COORD_BITS];
            p_xx_reg      <= PROD_W'(coef_xx_reg) * PROD_W'(x_s);
            p_xy_reg      <= PROD_W'(coef_xy_reg) * PROD_W'(y_s);
            p_wx_reg      <= PROD_W'(coef_wx_reg) * PROD_W'(x_s);
            p_wy_reg      <= PROD_W'(coef_wy_reg) * PROD_W'(y_s);
            s1_xc_reg     <= coef_xc_reg;
        end
    end

    // stage 2: numerator and denominator sums
    logic                    s2_valid_reg;
    logic                    s2_absent_reg;
    logic signed [SUM_W-1:0] num_reg;
    logic signed [SUM_W-1:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_absent_reg <= s1_absent_reg;
            num_reg <= SUM_W'(p_xx_reg) + SUM_W'(p_xy_reg) + SUM_W'(s1_xc_reg);
            den_reg <= SUM_W'(p_wx_reg) + SUM_W'(p_wy_reg)
                       + (SUM_W'(1) <<< FRAC_BITS);
        end
    end

    // stage 3 prep: magnitudes, rounding offset, range check
    logic [SUM_W-1:0] an;
    logic [SUM_W-1:0] ad;
    logic [MAG_W-1:0] n_mag;
    logic [MAG_W-1:0] d_mag;
    logic             den_zero;
    logic             too_big;
    beat_ctl_t        prep_ctl;

    always_comb
    begin
        an       = num_reg[SUM_W-1] ? SUM_W'(-num_reg) : SUM_W'(num_reg);
        ad       = den_reg[SUM_W-1] ? SUM_W'(-den_reg) : SUM_W'(den_reg);
        // rounded quotient is floor((2|n| + |d|) / 2|d|)
        n_mag    = (MAG_W'(an) << 1) + MAG_W'(ad);
        d_mag    = MAG_W'(ad) << 1;
        den_zero = (den_reg == '0);
        too_big  = n_mag >= (d_mag << QUO_W);
        prep_ctl.valid   = s2_valid_reg;
        prep_ctl.absent  = s2_absent_reg;
        prep_ctl.special = den_zero || too_big;
        prep_ctl.neg     = num_reg[SUM_W-1] ^ den_reg[SUM_W-1];
        prep_ctl.sat_neg = den_zero ? num_reg[SUM_W-1] : prep_ctl.neg;
    end

    beat_ctl_t        s3_ctl_reg;
    logic [MAG_W-1:0] s3_n_reg;
    logic [MAG_W-1:0] s3_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctl_reg <= '0;
        end
        else if (en)
        begin
            s3_ctl_reg <= prep_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_n_reg <= n_mag;
            s3_d_reg <= d_mag;
        end
    end

    // divider chain: cell k resolves quotient bit QUO_W-1-k
    beat_ctl_t        ch_ctl [0:QUO_W];
    logic [MAG_W-1:0] ch_rem [0:QUO_W];
    logic [MAG_W-1:0] ch_div [0:QUO_W];
    logic [QUO_W-1:0] ch_quo [0:QUO_W];

    assign ch_ctl[0] = s3_ctl_reg;
    assign ch_rem[0] = s3_n_reg;
    assign ch_div[0] = s3_d_reg;
    assign ch_quo[0] = '0;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_cell
        hcr_div_cell #(
            .MAG_W (MAG_W),
            .SHIFT (QUO_W - 1 - k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (ch_ctl[k]),
            .rem_in  (ch_rem[k]),
            .div_in  (ch_div[k]),
            .quo_in  (ch_quo[k]),
            .ctl_out (ch_ctl[k+1]),
            .rem_out (ch_rem[k+1]),
            .div_out (ch_div[k+1]),
            .quo_out (ch_quo[k+1])
        );
    end

    // output stage: absent point, saturation and sign
    beat_ctl_t               fin_ctl;
    logic [QUO_W-1:0]        fin_q;
    logic signed [OUT_W-1:0] col_next;
    logic signed [OUT_W-1:0] col_reg;

    assign fin_ctl = ch_ctl[QUO_W];
    assign fin_q   = ch_quo[QUO_W];

    always_comb
    begin
        if (fin_ctl.absent)
        begin
            col_next = OUT_ABSENT;
        end
        else if (fin_ctl.special)
        begin
            col_next = fin_ctl.sat_neg ? OUT_MIN : OUT_MAX;
        end
        else if (fin_ctl.neg)
        begin
            col_next = (fin_q > QUO_W'(32768)) ? OUT_MIN : OUT_W'(-fin_q);
        end
        else
        begin
            col_next = (fin_q > QUO_W'(32767)) ? OUT_MAX : OUT_W'(fin_q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign col_out   = col_reg;

`ifndef SYNTHESIS
    // the pipeline only stalls behind a held output beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("pipeline stalled without a held output beat");

    // a held output beat stays valid into the next cycle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output beat dropped while stalled");

    // a write to coef_xx lands in its register
    a_cfg_xx: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_index == REG_XX) |=> (coef_xx_reg == $past(cfg_data)))
        else $error("coef_xx write lost");
`endif

endmodule
